// ===== sv/rt_pkg.sv =====
// Shared types and constants for the 3x3 rank transform.
package rt_pkg;

	localparam int PIX_W = 8;
	localparam int RANK_W = 4;
	localparam int ROW_W = 11;
	localparam int COL_W = 11;
	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_TDATA_W = 32;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [CFG_W-1:0] MIN_SIZE = 12'd3;
	localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd2048;
	localparam logic [CFG_W-1:0] RST_WIDTH = 12'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// One queued item: the centre pixel, its eight neighbours, its position and the frame-last flag.
	typedef struct packed {
		logic [PIX_W-1:0] centre;
		logic [7:0][PIX_W-1:0] nbr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic last;
	} item_t;

endpackage

// ===== sv/rt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rt_front.sv =====
// Front end: accepts pixels, tracks position, keeps line buffers and window, queues interior items.
module rt_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rt_pkg::CFG_W-1:0]        cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rt_pkg::PIX_W-1:0]        s_axis_tdata,
	input  logic [rt_pkg::QCNT_W-1:0]       q_count,
	output logic                            push,
	output rt_pkg::item_t                   push_item
);

	localparam int CB = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int CLW = (WB > rt_pkg::CFG_W) ? WB : rt_pkg::CFG_W;
	localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam int PW = rt_pkg::PIX_W;

	logic [WB-1:0] width_q;
	logic [rt_pkg::CFG_W-1:0] height_q;
	logic [CB-1:0] col_q;
	logic [rt_pkg::ROW_W-1:0] row_q;
	logic [CLW-1:0] cfg_ext;

	logic accept;
	logic [WB:0] col_nxt;
	logic [rt_pkg::CFG_W-1:0] row_nxt;
	logic col_end, row_end;
	logic [31:0] col_m1;

	logic valid_s1, emit_s1, last_s1;
	logic [PW-1:0] pix_s1;
	logic [CB-1:0] col_s1;
	logic [rt_pkg::ROW_W-1:0] orow_s1;
	logic [rt_pkg::COL_W-1:0] ocol_s1;

	logic [2*PW-1:0] lb_rdata;
	logic [PW-1:0] top, mid;
	logic [PW-1:0] win_q [6];

	// Room is reserved for the item still in the read stage.
	assign s_axis_tready = ({1'b0, q_count} + {{rt_pkg::QCNT_W{1'b0}}, valid_s1})
		< (rt_pkg::QCNT_W + 1)'(rt_pkg::QDEPTH);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign cfg_ext = CLW'(cfg_data);
	assign col_nxt = (WB + 1)'(col_q) + 1'b1;
	assign row_nxt = {1'b0, row_q} + 1'b1;
	assign col_end = col_nxt >= {1'b0, width_q};
	assign row_end = row_nxt >= height_q;
	assign col_m1 = 32'(col_q) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WB'(RST_W);
			height_q <= rt_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			// Sizes are stored already saturated to the supported range.
			case (cfg_index)
				rt_pkg::REG_IMAGE_WIDTH: begin
					if (cfg_data < rt_pkg::MIN_SIZE) begin
						width_q <= WB'(rt_pkg::MIN_SIZE);
					end else if (cfg_ext > CLW'(MAX_WIDTH)) begin
						width_q <= WB'(MAX_WIDTH);
					end else begin
						width_q <= WB'(cfg_ext);
					end
				end
				rt_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data < rt_pkg::MIN_SIZE) begin
						height_q <= rt_pkg::MIN_SIZE;
					end else if (cfg_data > rt_pkg::MAX_HEIGHT) begin
						height_q <= rt_pkg::MAX_HEIGHT;
					end else begin
						height_q <= cfg_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_nxt[rt_pkg::ROW_W-1:0];
				end else begin
					col_q <= col_nxt[CB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			emit_s1 <= (row_q >= rt_pkg::ROW_W'(2)) && (32'(col_q) >= 32'd2);
			last_s1 <= row_end && col_end;
			orow_s1 <= row_q - 1'b1;
			ocol_s1 <= col_m1[rt_pkg::COL_W-1:0];
		end
	end

	// Upper byte holds the row two above, lower byte the row above.
	rt_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata ({mid, pix_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (lb_rdata)
	);

	assign top = lb_rdata[2*PW-1:PW];
	assign mid = lb_rdata[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pix_s1;
		end
	end

	assign push = valid_s1 && emit_s1;

	always_comb begin
		push_item.centre = win_q[4];
		push_item.nbr[0] = win_q[0];
		push_item.nbr[1] = win_q[1];
		push_item.nbr[2] = win_q[2];
		push_item.nbr[3] = win_q[3];
		push_item.nbr[4] = win_q[5];
		push_item.nbr[5] = top;
		push_item.nbr[6] = mid;
		push_item.nbr[7] = pix_s1;
		push_item.row = orow_s1;
		push_item.col = ocol_s1;
		push_item.last = last_s1;
	end

endmodule

// ===== sv/rt_fifo.sv =====
// Short queue of classified items between the front end and the rank stage.
module rt_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rt_pkg::item_t              push_item,
	input  logic                       pop,
	output rt_pkg::item_t              head,
	output logic                       not_empty,
	output logic [rt_pkg::QCNT_W-1:0]  count
);

	rt_pkg::item_t mem_q [rt_pkg::QDEPTH];
	logic [rt_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rt_pkg::QCNT_W-1:0] count_q;

	assign head = mem_q[rd_q];
	assign not_empty = count_q != '0;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/rt_back.sv =====
// Back end: counts brighter neighbours of the queue head and holds the output register.
module rt_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rt_pkg::item_t                     head,
	input  logic                              not_empty,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast
);

	localparam int PAD_W = rt_pkg::OUT_TDATA_W - rt_pkg::RANK_W - rt_pkg::ROW_W - rt_pkg::COL_W;

	logic [rt_pkg::RANK_W-1:0] rank;
	logic valid_q;

	always_comb begin
		rank = '0;
		for (int i = 0; i < 8; i++) begin
			rank = rank + rt_pkg::RANK_W'(head.nbr[i] > head.centre);
		end
	end

	assign pop = not_empty && (!valid_q || m_axis_tready);
	assign m_axis_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_axis_tdata <= {PAD_W'(0), head.col, head.row, rank};
			m_axis_tlast <= head.last;
		end
	end

endmodule

// ===== sv/rank_transform_3x3.sv =====
// An accepted pixel is registered in the read stage; its item is written into the queue, can
// wait there behind results not yet taken, and is then loaded into the output register.
// Throughput: one pixel per cycle while the queue has room; the single-port-per-side line
// buffer RAM is read and written once per pixel, and a four-entry queue decouples the window
// from the output. Reset clears position counters, window and all valid flags and returns
// the sizes to 640 x 480; the line buffers are not cleared and hold no meaning until written.
module rank_transform_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rt_pkg::CFG_W-1:0]          cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rt_pkg::PIX_W-1:0]          s_axis_tdata,  // [7:0] pixel
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rt_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [3:0] rank, [14:4] row, [25:15] col
	output logic                              m_axis_tlast   // frame_last
);

	logic push, pop, not_empty;
	rt_pkg::item_t push_item, head;
	logic [rt_pkg::QCNT_W-1:0] q_count;

	rt_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_count       (q_count),
		.push          (push),
		.push_item     (push_item)
	);

	rt_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (q_count)
	);

	rt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.not_empty     (not_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== sv/rt_checker.sv =====
// Port-level checks on the rank transform, bound to the top level.
module rt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [rt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                              m_axis_tlast
);

	// A result that is not taken stays offered unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// At most eight neighbours can be brighter.
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
		else $error("rank above eight");

	// Pixels of the top row or the left column are never emitted.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[14:4] != 11'd0) && (m_axis_tdata[25:15] != 11'd0))
		else $error("border pixel emitted");

	// Padding bits above the fields stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
		else $error("padding bits not zero");

endmodule

bind rank_transform_3x3 rt_checker u_rt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
